FILE: sv/rgb_to_hsv_8bit_unit_defines.svh
// Assertion macros for the checker of the RGB to HSV unit.
`ifndef RGB_TO_HSV_8BIT_UNIT_DEFINES_SVH
`define RGB_TO_HSV_8BIT_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define RHSV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define RHSV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: sv/rhsv_pkg.sv
`default_nettype none

package rhsv_pkg;

    localparam int CH_W      = 8;
    localparam int NUM_CELLS = CH_W;   // one quotient bit per cell
    localparam int NUM_LANES = 2;
    localparam int LANE_SAT  = 0;
    localparam int LANE_HUE  = 1;

    localparam logic [CH_W:0] DEG_RED_WRAP   = 9'd360;
    localparam logic [CH_W:0] DEG_GREEN_BASE = 9'd120;
    localparam logic [CH_W:0] DEG_BLUE_BASE  = 9'd240;

    typedef enum logic [1:0] {
        SEC_GREY  = 2'd0,
        SEC_RED   = 2'd1,
        SEC_GREEN = 2'd2,
        SEC_BLUE  = 2'd3
    } t_sector;

    // One restoring divider lane: partial remainder, numerator/quotient shifter, divisor.
    typedef struct packed {
        logic [CH_W-1:0] rem;
        logic [CH_W-1:0] sh;
        logic [CH_W-1:0] div;
    } t_lane;

    typedef t_lane [NUM_LANES-1:0] t_lanes;

    // Data that rides along the chain untouched.
    typedef struct packed {
        logic [CH_W-1:0] bright;
        t_sector         sector;
        logic            neg;
    } t_side;

endpackage

`default_nettype wire

FILE: sv/rhsv_front.sv
`default_nettype none

module rhsv_front
    import rhsv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [CH_W-1:0] i_red,
    input  logic [CH_W-1:0] i_green,
    input  logic [CH_W-1:0] i_blue,
    output logic            o_valid,
    output t_side           o_side,
    output t_lanes          o_lanes
);

    logic              r_valid;
    t_side             r_side;
    t_lanes            r_lanes;
    t_side             n_side;
    t_lanes            n_lanes;
    logic [CH_W-1:0]   w_max;
    logic [CH_W-1:0]   w_min;
    logic [CH_W-1:0]   w_delta;
    logic [CH_W:0]     w_diff;
    logic [CH_W-1:0]   w_mag;
    logic [2*CH_W-1:0] w_sat_num;
    logic [2*CH_W-1:0] w_hue_num;
    logic              w_r_top;
    logic              w_g_top;

    always_comb begin
        w_r_top = (i_red >= i_green) && (i_red >= i_blue);
        w_g_top = (i_green >= i_blue);
        if (w_r_top) begin
            w_max = i_red;
        end else if (w_g_top) begin
            w_max = i_green;
        end else begin
            w_max = i_blue;
        end
        if ((i_red <= i_green) && (i_red <= i_blue)) begin
            w_min = i_red;
        end else if (i_green <= i_blue) begin
            w_min = i_green;
        end else begin
            w_min = i_blue;
        end
        w_delta = w_max - w_min;

        // Pick the sector and the signed channel difference for it.
        if (w_delta == '0) begin
            n_side.sector = SEC_GREY;
            w_diff        = '0;
        end else if (w_r_top) begin
            n_side.sector = SEC_RED;
            w_diff        = {1'b0, i_green} - {1'b0, i_blue};
        end else if (w_g_top) begin
            n_side.sector = SEC_GREEN;
            w_diff        = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            n_side.sector = SEC_BLUE;
            w_diff        = {1'b0, i_red} - {1'b0, i_green};
        end
        n_side.neg    = w_diff[CH_W];
        n_side.bright = w_max;
        w_mag         = w_diff[CH_W] ? w_min - w_max + w_delta - w_diff[CH_W-1:0]
                                     : w_diff[CH_W-1:0];

        // 255*delta and 60*|diff| by shift and subtract.
        w_sat_num = {w_delta, {CH_W{1'b0}}} - {{CH_W{1'b0}}, w_delta};
        w_hue_num = {2'b00, w_mag, 6'b0} - {6'b0, w_mag, 2'b00};

        n_lanes[LANE_SAT].rem = w_sat_num[2*CH_W-1:CH_W];
        n_lanes[LANE_SAT].sh  = w_sat_num[CH_W-1:0];
        n_lanes[LANE_SAT].div = w_max;
        n_lanes[LANE_HUE].rem = w_hue_num[2*CH_W-1:CH_W];
        n_lanes[LANE_HUE].sh  = w_hue_num[CH_W-1:0];
        n_lanes[LANE_HUE].div = w_delta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_side  <= n_side;
        r_lanes <= n_lanes;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_lanes = r_lanes;

endmodule

`default_nettype wire

FILE: sv/rhsv_cell.sv
`default_nettype none

module rhsv_cell
    import rhsv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_side  i_side,
    input  t_lanes i_lanes,
    output logic   o_valid,
    output t_side  o_side,
    output t_lanes o_lanes
);

    logic          r_valid;
    t_side         r_side;
    t_lanes        r_lanes;
    t_lanes        n_lanes;
    logic [CH_W:0] w_trial [NUM_LANES];
    logic [CH_W:0] w_sub   [NUM_LANES];
    logic          w_ge    [NUM_LANES];

    // One restoring division step per lane: shift in a numerator bit, try the subtract.
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_trial[l] = {i_lanes[l].rem, i_lanes[l].sh[CH_W-1]};
            w_sub[l]   = w_trial[l] - {1'b0, i_lanes[l].div};
            w_ge[l]    = (w_trial[l] >= {1'b0, i_lanes[l].div});
            n_lanes[l].rem = w_ge[l] ? w_sub[l][CH_W-1:0] : w_trial[l][CH_W-1:0];
            n_lanes[l].sh  = {i_lanes[l].sh[CH_W-2:0], w_ge[l]};
            n_lanes[l].div = i_lanes[l].div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_side  <= i_side;
        r_lanes <= n_lanes;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_lanes = r_lanes;

endmodule

`default_nettype wire

FILE: sv/rhsv_back.sv
`default_nettype none

module rhsv_back
    import rhsv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_side           i_side,
    input  t_lanes          i_lanes,
    output logic            o_strobe,
    output logic [CH_W-1:0] o_hue,
    output logic [CH_W-1:0] o_saturation,
    output logic [CH_W-1:0] o_brightness
);

    logic            r_strobe;
    logic [CH_W-1:0] r_hue;
    logic [CH_W-1:0] r_sat;
    logic [CH_W-1:0] r_bright;
    logic [CH_W-1:0] n_sat;
    logic [CH_W:0]   w_q;
    logic [CH_W:0]   w_qc;
    logic [CH_W:0]   w_deg;

    always_comb begin
        w_q  = {1'b0, i_lanes[LANE_HUE].sh};
        // Ceiling of the quotient for negative floor divisions.
        w_qc = w_q + {{CH_W{1'b0}}, (i_lanes[LANE_HUE].rem != '0)};
        case (i_side.sector)
            SEC_RED: begin
                if (i_side.neg && (w_q != '0)) begin
                    w_deg = DEG_RED_WRAP - w_q;
                end else begin
                    w_deg = w_q;
                end
            end
            SEC_GREEN: w_deg = i_side.neg ? DEG_GREEN_BASE - w_qc : DEG_GREEN_BASE + w_q;
            SEC_BLUE:  w_deg = i_side.neg ? DEG_BLUE_BASE - w_qc : DEG_BLUE_BASE + w_q;
            default:   w_deg = '0;
        endcase
        n_sat = (i_side.bright == '0) ? '0 : i_lanes[LANE_SAT].sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
        r_hue    <= w_deg[CH_W:1];
        r_sat    <= n_sat;
        r_bright <= i_side.bright;
    end

    assign o_strobe     = r_strobe;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

endmodule

`default_nettype wire

FILE: sv/rgb_to_hsv_8bit_unit.sv
// RGB to HSV converter, 8 bits per channel, hue in two-degree steps (0..179).
//
// Input: drive i_red, i_green, i_blue and raise start; the pixel transfers at
// every rising edge with start high and busy low. busy stays low, so a new
// pixel may transfer in every cycle: one pixel per clock sustained.
// Output: o_hue, o_saturation, o_brightness are valid for exactly one cycle
// while o_strobe is high. There is no backpressure; the receiver must take
// each result in the cycle it appears.
// Each pixel passes the input stage, the eight division cells and the output
// stage, each of them registered; results leave in transfer order.
// Structure: an input stage finds max, min, delta, hue sector and scales the
// numerators (255*delta, 60*|diff|); a row of eight identical cells then
// runs two restoring dividers side by side, one quotient bit per cell; an
// output stage folds the hue quotient into degrees, halves it and clears
// saturation when brightness is zero.
// Reset (i_rst_n low, synchronous): clear all valid flags in the chain, so
// no strobe appears for pixels in flight; data registers are not reset.

`default_nettype none

module rgb_to_hsv_8bit_unit
    import rhsv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [CH_W-1:0] i_red,
    input  logic [CH_W-1:0] i_green,
    input  logic [CH_W-1:0] i_blue,
    output logic            o_strobe,
    output logic [CH_W-1:0] o_hue,
    output logic [CH_W-1:0] o_saturation,
    output logic [CH_W-1:0] o_brightness
);

    logic   c_valid [NUM_CELLS+1];
    t_side  c_side  [NUM_CELLS+1];
    t_lanes c_lanes [NUM_CELLS+1];

    // The pipeline never stalls, so accept a pixel in every cycle.
    assign busy = 1'b0;

    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (c_valid[0]),
        .o_side  (c_side[0]),
        .o_lanes (c_lanes[0])
    );

    // Division row: each cell retires one quotient bit of both dividers.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        rhsv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .i_side  (c_side[k]),
            .i_lanes (c_lanes[k]),
            .o_valid (c_valid[k+1]),
            .o_side  (c_side[k+1]),
            .o_lanes (c_lanes[k+1])
        );
    end

    rhsv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (c_valid[NUM_CELLS]),
        .i_side       (c_side[NUM_CELLS]),
        .i_lanes      (c_lanes[NUM_CELLS]),
        .o_strobe     (o_strobe),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

endmodule

`default_nettype wire

FILE: sv/rhsv_checker.sv
`default_nettype none

`include "rgb_to_hsv_8bit_unit_defines.svh"

module rhsv_checker
    import rhsv_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic            o_strobe,
    input logic [CH_W-1:0] o_hue,
    input logic [CH_W-1:0] o_saturation
);

    `RHSV_ASSERT_ALWAYS(a_never_busy, busy == 1'b0, "busy raised")
    `RHSV_ASSERT(a_latency, (start && !busy) |-> ##10 o_strobe, "result missing after transfer")
    `RHSV_ASSERT(a_no_spurious, (!start) |-> ##10 !o_strobe, "result without transfer")
    `RHSV_ASSERT(a_hue_range, o_strobe |-> (o_hue <= 8'd179), "hue out of range")
    `RHSV_ASSERT(a_grey_hue, (o_strobe && (o_saturation == '0)) |-> (o_hue == '0), "grey with hue")

endmodule

bind rgb_to_hsv_8bit_unit rhsv_checker u_rhsv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_hue        (o_hue),
    .o_saturation (o_saturation)
);

`default_nettype wire
